### rtl/rvp_pkg.sv
// Shared types, constants and the control program of the rotation velocity profiler.
package rvp_pkg;

    // Fixed-point format and field widths
    localparam int FRAC_BITS = 12;
    localparam int ANGLE_W   = 16;
    localparam int REM_W     = 18;
    localparam int ACC_W     = 18;
    localparam int SPEED_W   = 13;
    localparam int RATE_W    = 14;
    localparam int GAIN_W    = 16;
    localparam int SQ_W      = 2 * SPEED_W;
    localparam int LHS_W     = SQ_W + GAIN_W;
    localparam int BRAKE_SHIFT = FRAC_BITS + GAIN_W;
    localparam int RHS_W     = REM_W + BRAKE_SHIFT;

    // Pi rounded to the fixed-point format
    localparam longint unsigned PI_Q32 = 64'd13493037705;
    localparam longint unsigned PI_ROUND =
        (PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    localparam logic signed [ACC_W-1:0] PI_FX     = ACC_W'(PI_ROUND);
    localparam logic signed [ACC_W-1:0] NEG_PI_FX = -PI_FX;
    localparam logic signed [ACC_W-1:0] TWO_PI_FX = ACC_W'(2 * PI_ROUND);

    // Saturation limits of the remaining angle
    localparam logic signed [REM_W-1:0] REM_MAX = {1'b0, {(REM_W-1){1'b1}}};
    localparam logic signed [REM_W-1:0] REM_MIN = {1'b1, {(REM_W-1){1'b0}}};

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_TOL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FINE_ZONE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_MRG = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DECEL     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 3'd7;
    localparam int CFG_DATA_W = 16;

    // Configuration reset values
    localparam logic [11:0] RST_STOP_TOL  = 12'd41;
    localparam logic [12:0] RST_FINE_ZONE = 13'd614;
    localparam logic [12:0] RST_BRAKE_MRG = 13'd1229;
    localparam logic [11:0] RST_MIN_SPEED = 12'd410;
    localparam logic [11:0] RST_MAX_SPEED = 12'd2048;
    localparam logic [11:0] RST_ACCEL     = 12'd328;
    localparam logic [11:0] RST_DECEL     = 12'd655;
    localparam logic [15:0] RST_GAIN      = 16'd20480;

    typedef struct packed {
        logic [11:0] stop_tol;
        logic [12:0] fine_zone;
        logic [12:0] brake_margin;
        logic [11:0] min_speed;
        logic [11:0] max_speed;
        logic [11:0] accel_step;
        logic [11:0] decel_step;
        logic [15:0] braking_gain;
    } cfg_t;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD_IN,
        OP_START,
        OP_LATCH,
        OP_WRAP,
        OP_SUB,
        OP_ABS,
        OP_MUL,
        OP_SPEED,
        OP_FINE,
        OP_STOP,
        OP_EMIT
    } op_t;

    // Jump conditions
    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_SAMPLE,
        COND_NOT_ACTIVE,
        COND_ABS_LE_TOL,
        COND_ACC_OUT,
        COND_MAG_LE_FINE,
        COND_OUT_FREE
    } cond_t;

    // Program steps
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;
    localparam step_t STEP_IDLE   = 4'd0;
    localparam step_t STEP_DECODE = 4'd1;
    localparam step_t STEP_START  = 4'd2;
    localparam step_t STEP_CHECK  = 4'd3;
    localparam step_t STEP_LATCH  = 4'd4;
    localparam step_t STEP_TOL    = 4'd5;
    localparam step_t STEP_WRAP   = 4'd6;
    localparam step_t STEP_SUB    = 4'd7;
    localparam step_t STEP_ABS    = 4'd8;
    localparam step_t STEP_MUL    = 4'd9;
    localparam step_t STEP_SPEED  = 4'd10;
    localparam step_t STEP_FINE   = 4'd11;
    localparam step_t STEP_STOP   = 4'd12;
    localparam step_t STEP_EMIT   = 4'd13;
    localparam step_t STEP_HOLD   = 4'd14;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    // Status from datapath to sequencer
    typedef struct packed {
        logic in_valid;
        logic sample;
        logic not_active;
        logic abs_le_tol;
        logic acc_out;
        logic mag_le_fine;
        logic out_free;
    } flags_t;

    // Control program: one word per step
    function automatic ctrl_word_t program_rom(input step_t step);
        ctrl_word_t w;
        w = '{op: OP_NONE, cond: COND_ALWAYS, target: STEP_IDLE};
        unique case (step)
            STEP_IDLE:   w = '{op: OP_LOAD_IN, cond: COND_NO_INPUT,    target: STEP_IDLE};
            STEP_DECODE: w = '{op: OP_NONE,    cond: COND_SAMPLE,      target: STEP_CHECK};
            STEP_START:  w = '{op: OP_START,   cond: COND_ALWAYS,      target: STEP_EMIT};
            STEP_CHECK:  w = '{op: OP_NONE,    cond: COND_NOT_ACTIVE,  target: STEP_STOP};
            STEP_LATCH:  w = '{op: OP_LATCH,   cond: COND_NEVER,       target: STEP_IDLE};
            STEP_TOL:    w = '{op: OP_NONE,    cond: COND_ABS_LE_TOL,  target: STEP_STOP};
            STEP_WRAP:   w = '{op: OP_WRAP,    cond: COND_ACC_OUT,     target: STEP_WRAP};
            STEP_SUB:    w = '{op: OP_SUB,     cond: COND_NEVER,       target: STEP_IDLE};
            STEP_ABS:    w = '{op: OP_ABS,     cond: COND_NEVER,       target: STEP_IDLE};
            STEP_MUL:    w = '{op: OP_MUL,     cond: COND_MAG_LE_FINE, target: STEP_FINE};
            STEP_SPEED:  w = '{op: OP_SPEED,   cond: COND_ALWAYS,      target: STEP_EMIT};
            STEP_FINE:   w = '{op: OP_FINE,    cond: COND_ALWAYS,      target: STEP_EMIT};
            STEP_STOP:   w = '{op: OP_STOP,    cond: COND_NEVER,       target: STEP_IDLE};
            STEP_EMIT:   w = '{op: OP_EMIT,    cond: COND_OUT_FREE,    target: STEP_IDLE};
            STEP_HOLD:   w = '{op: OP_NONE,    cond: COND_ALWAYS,      target: STEP_EMIT};
            default:     w = '{op: OP_NONE,    cond: COND_ALWAYS,      target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

### rtl/rvp_seq.sv
// Step counter, control store and jump logic of the rotation velocity profiler.
module rvp_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  rvp_pkg::flags_t     flags,
    output rvp_pkg::ctrl_word_t ctrl,
    output logic                in_ready
);

    rvp_pkg::step_t step_reg;
    rvp_pkg::step_t step_next;
    logic           jump;

    // Fetch the control word of the current step
    always_comb
    begin
        ctrl = rvp_pkg::program_rom(step_reg);
    end

    // Evaluate the jump condition
    always_comb
    begin
        unique case (ctrl.cond)
            rvp_pkg::COND_NEVER:       jump = 1'b0;
            rvp_pkg::COND_ALWAYS:      jump = 1'b1;
            rvp_pkg::COND_NO_INPUT:    jump = !flags.in_valid;
            rvp_pkg::COND_SAMPLE:      jump = flags.sample;
            rvp_pkg::COND_NOT_ACTIVE:  jump = flags.not_active;
            rvp_pkg::COND_ABS_LE_TOL:  jump = flags.abs_le_tol;
            rvp_pkg::COND_ACC_OUT:     jump = flags.acc_out;
            rvp_pkg::COND_MAG_LE_FINE: jump = flags.mag_le_fine;
            rvp_pkg::COND_OUT_FREE:    jump = flags.out_free;
            default:                   jump = 1'b0;
        endcase
    end

    // Advance or jump
    always_comb
    begin
        step_next = jump ? ctrl.target : step_reg + rvp_pkg::step_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= rvp_pkg::STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // Take an item only at the idle step
    assign in_ready = (step_reg == rvp_pkg::STEP_IDLE);

endmodule

### rtl/rvp_dp.sv
// Datapath of the rotation velocity profiler: state, working registers and result register.
module rvp_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rvp_pkg::ctrl_word_t               ctrl,
    input  rvp_pkg::cfg_t                     cfg,
    input  logic                              in_valid,
    input  logic                              operation,
    input  logic signed [rvp_pkg::ANGLE_W-1:0] angle,
    input  logic                              out_ready,
    output rvp_pkg::flags_t                   flags,
    output logic                              out_valid,
    output logic signed [rvp_pkg::RATE_W-1:0] rate_command,
    output logic                              command_valid,
    output logic                              rotating
);

    localparam int ANGLE_W = rvp_pkg::ANGLE_W;
    localparam int REM_W   = rvp_pkg::REM_W;
    localparam int ACC_W   = rvp_pkg::ACC_W;
    localparam int SPEED_W = rvp_pkg::SPEED_W;
    localparam int RATE_W  = rvp_pkg::RATE_W;
    localparam int SQ_W    = rvp_pkg::SQ_W;
    localparam int LHS_W   = rvp_pkg::LHS_W;
    localparam int RHS_W   = rvp_pkg::RHS_W;

    // Rotation state
    logic signed [REM_W-1:0]   rem_reg, rem_next;
    logic signed [ANGLE_W-1:0] head_reg, head_next;
    logic [SPEED_W-1:0]        speed_reg, speed_next;
    logic                      active_reg, active_next;
    logic                      await_reg, await_next;

    // Working registers
    logic                      op_reg, op_next;
    logic signed [ANGLE_W-1:0] ang_reg, ang_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [REM_W-1:0]          mag_reg, mag_next;
    logic [SQ_W-1:0]           sq_reg, sq_next;
    logic [LHS_W-1:0]          lhs_reg, lhs_next;
    logic signed [RATE_W-1:0]  res_rate_reg, res_rate_next;
    logic                      res_cmd_reg, res_cmd_next;
    logic                      res_rot_reg, res_rot_next;

    // Output register
    logic                      out_valid_reg, out_valid_next;
    logic signed [RATE_W-1:0]  out_rate_reg, out_rate_next;
    logic                      out_cmd_reg, out_cmd_next;
    logic                      out_rot_reg, out_rot_next;

    // Derived values
    logic [REM_W-1:0]          rem_abs;
    logic signed [REM_W:0]     rem_diff;
    logic signed [REM_W:0]     margin;
    logic                      margin_pos;
    logic [RHS_W-1:0]          brake_rhs;
    logic                      brake;
    logic signed [SPEED_W:0]   dec_speed;
    logic [SPEED_W-1:0]        brake_speed;
    logic [SPEED_W-1:0]        accel_speed;
    logic [SPEED_W-1:0]        new_speed;
    logic                      out_free;

    // Apply the sign of the remaining angle to a speed
    function automatic logic signed [RATE_W-1:0] signed_rate(
        input logic [SPEED_W-1:0] mag,
        input logic               neg
    );
        logic signed [RATE_W-1:0] r;
        r = $signed({1'b0, mag});
        return neg ? -r : r;
    endfunction

    // Magnitude, difference for the saturating subtract, braking decision and new speed
    always_comb
    begin
        rem_abs    = rem_reg[REM_W-1] ? REM_W'(-rem_reg) : REM_W'(rem_reg);
        rem_diff   = (REM_W+1)'(rem_reg) - (REM_W+1)'(acc_reg);
        margin     = $signed({1'b0, mag_reg}) - $signed((REM_W+1)'(cfg.brake_margin));
        margin_pos = !margin[REM_W] && (margin != '0);
        brake_rhs  = RHS_W'(margin[REM_W-1:0]) << rvp_pkg::BRAKE_SHIFT;
        brake      = !margin_pos || (RHS_W'(lhs_reg) >= brake_rhs);
        dec_speed  = $signed({1'b0, speed_reg}) - $signed((SPEED_W+1)'(cfg.decel_step));
        if (dec_speed < $signed((SPEED_W+1)'(cfg.min_speed)))
        begin
            brake_speed = SPEED_W'(cfg.min_speed);
        end
        else
        begin
            brake_speed = dec_speed[SPEED_W-1:0];
        end
        accel_speed = speed_reg + SPEED_W'(cfg.accel_step);
        if (brake)
        begin
            new_speed = brake_speed;
        end
        else if (speed_reg < SPEED_W'(cfg.max_speed))
        begin
            new_speed = accel_speed;
        end
        else
        begin
            new_speed = SPEED_W'(cfg.max_speed);
        end
    end

    // Execute the operation of the current step
    always_comb
    begin
        rem_next      = rem_reg;
        head_next     = head_reg;
        speed_next    = speed_reg;
        active_next   = active_reg;
        await_next    = await_reg;
        op_next       = op_reg;
        ang_next      = ang_reg;
        acc_next      = acc_reg;
        mag_next      = mag_reg;
        sq_next       = sq_reg;
        lhs_next      = lhs_reg;
        res_rate_next = res_rate_reg;
        res_cmd_next  = res_cmd_reg;
        res_rot_next  = res_rot_reg;
        unique case (ctrl.op)
            rvp_pkg::OP_LOAD_IN:
            begin
                if (in_valid)
                begin
                    op_next  = operation;
                    ang_next = angle;
                end
            end
            rvp_pkg::OP_START:
            begin
                rem_next      = REM_W'(ang_reg);
                speed_next    = '0;
                active_next   = 1'b1;
                await_next    = 1'b1;
                res_rate_next = '0;
                res_cmd_next  = 1'b0;
                res_rot_next  = 1'b1;
            end
            rvp_pkg::OP_LATCH:
            begin
                // first sample latches the heading and takes a zero change
                if (await_reg)
                begin
                    head_next  = ang_reg;
                    await_next = 1'b0;
                    acc_next   = '0;
                end
                else
                begin
                    acc_next = ACC_W'(ang_reg) - ACC_W'(head_reg);
                end
                mag_next = rem_abs;
            end
            rvp_pkg::OP_WRAP:
            begin
                // one correction by a full turn toward (-pi, pi]
                if (acc_reg > rvp_pkg::PI_FX)
                begin
                    acc_next = acc_reg - rvp_pkg::TWO_PI_FX;
                end
                else if (acc_reg <= rvp_pkg::NEG_PI_FX)
                begin
                    acc_next = acc_reg + rvp_pkg::TWO_PI_FX;
                end
            end
            rvp_pkg::OP_SUB:
            begin
                if (rem_diff[REM_W] != rem_diff[REM_W-1])
                begin
                    rem_next = rem_diff[REM_W] ? rvp_pkg::REM_MIN : rvp_pkg::REM_MAX;
                end
                else
                begin
                    rem_next = rem_diff[REM_W-1:0];
                end
            end
            rvp_pkg::OP_ABS:
            begin
                mag_next = rem_abs;
                sq_next  = speed_reg * speed_reg;
            end
            rvp_pkg::OP_MUL:
            begin
                lhs_next = sq_reg * cfg.braking_gain;
            end
            rvp_pkg::OP_SPEED:
            begin
                speed_next    = new_speed;
                head_next     = ang_reg;
                res_rate_next = signed_rate(new_speed, rem_reg[REM_W-1]);
                res_cmd_next  = 1'b1;
                res_rot_next  = 1'b1;
            end
            rvp_pkg::OP_FINE:
            begin
                head_next    = ang_reg;
                res_cmd_next = 1'b1;
                res_rot_next = 1'b1;
                if (mag_reg > REM_W'(cfg.stop_tol))
                begin
                    res_rate_next = signed_rate(SPEED_W'(cfg.min_speed), rem_reg[REM_W-1]);
                end
                else
                begin
                    speed_next    = '0;
                    rem_next      = '0;
                    res_rate_next = '0;
                end
            end
            rvp_pkg::OP_STOP:
            begin
                active_next   = 1'b0;
                res_rate_next = '0;
                res_cmd_next  = 1'b0;
                res_rot_next  = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // Load the output register when it is free, drop it when taken
    always_comb
    begin
        out_free       = !out_valid_reg || out_ready;
        out_valid_next = out_valid_reg && !out_ready;
        out_rate_next  = out_rate_reg;
        out_cmd_next   = out_cmd_reg;
        out_rot_next   = out_rot_reg;
        if ((ctrl.op == rvp_pkg::OP_EMIT) && out_free)
        begin
            out_valid_next = 1'b1;
            out_rate_next  = res_rate_reg;
            out_cmd_next   = res_cmd_reg;
            out_rot_next   = res_rot_reg;
        end
    end

    // Control and rotation state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            head_reg      <= '0;
            speed_reg     <= '0;
            active_reg    <= 1'b0;
            await_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rem_reg       <= rem_next;
            head_reg      <= head_next;
            speed_reg     <= speed_next;
            active_reg    <= active_next;
            await_reg     <= await_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        ang_reg      <= ang_next;
        acc_reg      <= acc_next;
        mag_reg      <= mag_next;
        sq_reg       <= sq_next;
        lhs_reg      <= lhs_next;
        res_rate_reg <= res_rate_next;
        res_cmd_reg  <= res_cmd_next;
        res_rot_reg  <= res_rot_next;
        out_rate_reg <= out_rate_next;
        out_cmd_reg  <= out_cmd_next;
        out_rot_reg  <= out_rot_next;
    end

    // Status for the sequencer
    always_comb
    begin
        flags.in_valid    = in_valid;
        flags.sample      = op_reg;
        flags.not_active  = !active_reg;
        flags.abs_le_tol  = mag_reg <= REM_W'(cfg.stop_tol);
        flags.acc_out     = (acc_reg > rvp_pkg::PI_FX) || (acc_reg <= rvp_pkg::NEG_PI_FX);
        flags.mag_le_fine = mag_reg <= REM_W'(cfg.fine_zone);
        flags.out_free    = out_free;
    end

    assign out_valid     = out_valid_reg;
    assign rate_command  = out_rate_reg;
    assign command_valid = out_cmd_reg;
    assign rotating      = out_rot_reg;

endmodule

### rtl/rotation_velocity_profiler.sv
// Top level of the rotation velocity profiler: configuration registers, sequencer and datapath.
//
// One item at a time runs through a 15-step microprogram. A start item, a heading sample
// while idle, a sample that ends the rotation and a profiled sample each take their own
// path through the steps; a profiled sample runs the wrap step once more per full-turn wrap
// correction of the heading change (0 to 3) and also runs the two registered multiplies of
// the braking test. A result waits in an output register; the next item is accepted while
// it waits, and the block stalls only when a second result is ready before the first is
// taken, retrying the emit step via the hold step. The configuration port is always ready
// and should be written only while no item is in progress.
module rotation_velocity_profiler (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 operation,
    input  logic signed [rvp_pkg::ANGLE_W-1:0]   angle,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [rvp_pkg::RATE_W-1:0]    rate_command,
    output logic                                 command_valid,
    output logic                                 rotating,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rvp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rvp_pkg::CFG_DATA_W-1:0]       cfg_data
);

    rvp_pkg::cfg_t       cfg_reg, cfg_next;
    rvp_pkg::ctrl_word_t ctrl;
    rvp_pkg::flags_t     flags;

    // Write one configuration register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                rvp_pkg::CFG_STOP_TOL:  cfg_next.stop_tol     = cfg_data[11:0];
                rvp_pkg::CFG_FINE_ZONE: cfg_next.fine_zone    = cfg_data[12:0];
                rvp_pkg::CFG_BRAKE_MRG: cfg_next.brake_margin = cfg_data[12:0];
                rvp_pkg::CFG_MIN_SPEED: cfg_next.min_speed    = cfg_data[11:0];
                rvp_pkg::CFG_MAX_SPEED: cfg_next.max_speed    = cfg_data[11:0];
                rvp_pkg::CFG_ACCEL:     cfg_next.accel_step   = cfg_data[11:0];
                rvp_pkg::CFG_DECEL:     cfg_next.decel_step   = cfg_data[11:0];
                rvp_pkg::CFG_GAIN:      cfg_next.braking_gain = cfg_data[15:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stop_tol     <= rvp_pkg::RST_STOP_TOL;
            cfg_reg.fine_zone    <= rvp_pkg::RST_FINE_ZONE;
            cfg_reg.brake_margin <= rvp_pkg::RST_BRAKE_MRG;
            cfg_reg.min_speed    <= rvp_pkg::RST_MIN_SPEED;
            cfg_reg.max_speed    <= rvp_pkg::RST_MAX_SPEED;
            cfg_reg.accel_step   <= rvp_pkg::RST_ACCEL;
            cfg_reg.decel_step   <= rvp_pkg::RST_DECEL;
            cfg_reg.braking_gain <= rvp_pkg::RST_GAIN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;

    // Sequencer
    rvp_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .flags    (flags),
        .ctrl     (ctrl),
        .in_ready (in_ready)
    );

    // Datapath
    rvp_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .cfg           (cfg_reg),
        .in_valid      (in_valid),
        .operation     (operation),
        .angle         (angle),
        .out_ready     (out_ready),
        .flags         (flags),
        .out_valid     (out_valid),
        .rate_command  (rate_command),
        .command_valid (command_valid),
        .rotating      (rotating)
    );

    // An accepted item keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken again right after an accepted item");

    // A rate command is only issued during a rotation
    a_cmd_rotating: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && command_valid) |-> rotating)
        else $error("rate command issued while not rotating");

    // A stop tolerance write lands in its register
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && (cfg_index == rvp_pkg::CFG_STOP_TOL))
        |=> (cfg_reg.stop_tol == $past(cfg_data[11:0])))
        else $error("stop tolerance write lost");

endmodule
